// ===== hw/rtl/rgt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rgt_pkg;

    // register map
    localparam int unsigned REG_GRID_SIZE_LOG2 = 0;
    localparam logic [3:0]  GRID_LOG2_RESET    = 4'd10;

    localparam int unsigned EXTENT_BITS = 15;
    localparam int unsigned LOG2_BITS   = 4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PLAN,
        ST_CHECK,
        ST_ERR,
        ST_WALK
    } rgt_state_t;

    typedef struct packed {
        logic load;
        logic plan;
        logic emit_tile;
        logic emit_err;
    } rgt_cmd_t;

    typedef struct packed {
        logic too_many;
        logic empty;
        logic last_col;
        logic last_row;
        logic out_free;
    } rgt_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rgt_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface rgt_rect_if #(
    parameter int COORD_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_BITS-1:0]  rect_x;
    logic signed [COORD_BITS-1:0]  rect_y;
    logic [14:0]                   rect_width;
    logic [14:0]                   rect_height;

    modport source (output valid, output rect_x, output rect_y,
                    output rect_width, output rect_height, input ready);
    modport sink (input valid, input rect_x, input rect_y,
                  input rect_width, input rect_height, output ready);
endinterface

interface rgt_tile_if #(
    parameter int COORD_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_BITS-1:0]  tile_x;
    logic signed [COORD_BITS-1:0]  tile_y;
    logic [14:0]                   tile_width;
    logic [14:0]                   tile_height;
    logic                          last_tile;
    logic                          span_error;

    modport source (output valid, output tile_x, output tile_y, output tile_width,
                    output tile_height, output last_tile, output span_error,
                    input ready);
    modport sink (input valid, input tile_x, input tile_y, input tile_width,
                  input tile_height, input last_tile, input span_error,
                  output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/rgt_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rgt_regs (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output logic [rgt_pkg::LOG2_BITS-1:0] grid_log2
);
    import rgt_pkg::*;

    logic [LOG2_BITS-1:0] grid_log2_reg;
    logic [LOG2_BITS-1:0] grid_log2_next;
    logic                 wr_en;
    logic                 sel_grid;

    // byte address 4*i, low bits ignored
    assign sel_grid = (32'(paddr[2]) == REG_GRID_SIZE_LOG2);
    assign wr_en    = psel && penable && pwrite && pready;
    assign pready   = 1'b1;

    always_comb
    begin
        grid_log2_next = grid_log2_reg;
        if (wr_en && sel_grid)
        begin
            grid_log2_next = pwdata[LOG2_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_log2_reg <= GRID_LOG2_RESET;
        end
        else
        begin
            grid_log2_reg <= grid_log2_next;
        end
    end

    assign prdata    = sel_grid ? {{(32-LOG2_BITS){1'b0}}, grid_log2_reg} : 32'd0;
    assign grid_log2 = grid_log2_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/rgt_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rgt_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire rgt_pkg::rgt_status_t  status,
    output rgt_pkg::rgt_cmd_t          cmd
);
    import rgt_pkg::*;

    rgt_state_t state_reg;
    rgt_state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_PLAN;
                end
            end
            ST_PLAN:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                priority if (status.too_many)
                begin
                    state_next = ST_ERR;
                end
                else if (status.empty)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_WALK;
                end
            end
            ST_ERR:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_WALK:
            begin
                if (status.out_free && status.last_col && status.last_row)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready      = 1'b0;
        cmd           = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_PLAN:
            begin
                cmd.plan = 1'b1;
            end
            ST_CHECK:
            begin
            end
            ST_ERR:
            begin
                cmd.emit_err = status.out_free;
            end
            ST_WALK:
            begin
                cmd.emit_tile = status.out_free;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/rgt_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rgt_dp #(
    parameter int MAX_CELLS_PER_AXIS = 8,
    parameter int COORD_BITS         = 16
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic [rgt_pkg::LOG2_BITS-1:0] grid_log2,
    input  wire rgt_pkg::rgt_cmd_t            cmd,
    output rgt_pkg::rgt_status_t              status,
    input  wire logic signed [COORD_BITS-1:0] rect_x,
    input  wire logic signed [COORD_BITS-1:0] rect_y,
    input  wire logic [14:0]                  rect_width,
    input  wire logic [14:0]                  rect_height,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic signed [COORD_BITS-1:0]      tile_x,
    output logic signed [COORD_BITS-1:0]      tile_y,
    output logic [14:0]                       tile_width,
    output logic [14:0]                       tile_height,
    output logic                              last_tile,
    output logic                              span_error
);
    import rgt_pkg::*;

    // room for start + extent, the cell edges beyond it and the sign
    localparam int DW  = ((COORD_BITS > 16) ? COORD_BITS : 16) + 3;
    localparam int CNT = $clog2(MAX_CELLS_PER_AXIS + 1);
    localparam logic signed [DW-1:0] MAXC = DW'(MAX_CELLS_PER_AXIS);

    function automatic logic signed [DW-1:0] clamp(
        input logic signed [DW-1:0] v,
        input logic signed [DW-1:0] lo,
        input logic signed [DW-1:0] hi
    );
        logic signed [DW-1:0] r;
        r = v;
        if (v < lo)
        begin
            r = lo;
        end
        else if (v > hi)
        begin
            r = hi;
        end
        return r;
    endfunction

    logic signed [DW-1:0] sx_reg, sy_reg, ex_reg, ey_reg;
    logic signed [DW-1:0] ncol_reg, nrow_reg;
    logic signed [DW-1:0] minx_reg, maxx_reg, miny_reg, maxy_reg;
    logic signed [DW-1:0] miny0_reg, maxy0_reg;
    logic [CNT-1:0]       col_reg, row_reg;

    logic signed [DW-1:0] step;
    logic signed [DW-1:0] low_mask;
    logic signed [DW-1:0] sx_in, sy_in;
    logic signed [DW-1:0] first_col, first_row, end_col, end_row;
    logic signed [DW-1:0] minx0, miny0;
    logic signed [DW-1:0] px, py, wx, wy;
    logic                 last_col, last_row, out_free;

    logic                         out_valid_reg, out_valid_next;
    logic signed [COORD_BITS-1:0] tile_x_reg, tile_y_reg;
    logic [14:0]                  tile_w_reg, tile_h_reg;
    logic                         last_reg, err_reg;

    assign step     = DW'(1) <<< grid_log2;
    assign low_mask = step - DW'(1);
    assign sx_in    = {{(DW-COORD_BITS){rect_x[COORD_BITS-1]}}, rect_x};
    assign sy_in    = {{(DW-COORD_BITS){rect_y[COORD_BITS-1]}}, rect_y};

    // floor and ceiling of the edges over the spacing
    assign first_col = sx_reg >>> grid_log2;
    assign first_row = sy_reg >>> grid_log2;
    assign end_col   = (ex_reg + low_mask) >>> grid_log2;
    assign end_row   = (ey_reg + low_mask) >>> grid_log2;
    assign minx0     = sx_reg & ~low_mask;
    assign miny0     = sy_reg & ~low_mask;

    assign px = clamp(sx_reg, minx_reg, maxx_reg);
    assign py = clamp(sy_reg, miny_reg, maxy_reg);
    assign wx = clamp(ex_reg, minx_reg, maxx_reg) - px;
    assign wy = clamp(ey_reg, miny_reg, maxy_reg) - py;

    assign last_col = (CNT'(col_reg + 1'b1) == ncol_reg[CNT-1:0]);
    assign last_row = (CNT'(row_reg + 1'b1) == nrow_reg[CNT-1:0]);
    assign out_free = !out_valid_reg || out_ready;

    assign status.too_many = (ncol_reg > MAXC) || (nrow_reg > MAXC);
    assign status.empty    = (ncol_reg <= DW'(0)) || (nrow_reg <= DW'(0));
    assign status.last_col = last_col;
    assign status.last_row = last_row;
    assign status.out_free = out_free;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sx_reg <= sx_in;
            sy_reg <= sy_in;
            ex_reg <= sx_in + {{(DW-EXTENT_BITS){1'b0}}, rect_width};
            ey_reg <= sy_in + {{(DW-EXTENT_BITS){1'b0}}, rect_height};
        end
        if (cmd.plan)
        begin
            ncol_reg  <= end_col - first_col;
            nrow_reg  <= end_row - first_row;
            minx_reg  <= minx0;
            maxx_reg  <= minx0 + step;
            miny_reg  <= miny0;
            maxy_reg  <= miny0 + step;
            miny0_reg <= miny0;
            maxy0_reg <= miny0 + step;
            col_reg   <= '0;
            row_reg   <= '0;
        end
        if (cmd.emit_tile)
        begin
            // rows run fastest, then the next column
            if (last_row)
            begin
                row_reg  <= '0;
                miny_reg <= miny0_reg;
                maxy_reg <= maxy0_reg;
                col_reg  <= CNT'(col_reg + 1'b1);
                minx_reg <= minx_reg + step;
                maxx_reg <= maxx_reg + step;
            end
            else
            begin
                row_reg  <= CNT'(row_reg + 1'b1);
                miny_reg <= miny_reg + step;
                maxy_reg <= maxy_reg + step;
            end
        end
    end

    // output beat register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit_tile || cmd.emit_err)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_tile)
        begin
            tile_x_reg <= px[COORD_BITS-1:0];
            tile_y_reg <= py[COORD_BITS-1:0];
            tile_w_reg <= wx[EXTENT_BITS-1:0];
            tile_h_reg <= wy[EXTENT_BITS-1:0];
            last_reg   <= last_col && last_row;
            err_reg    <= 1'b0;
        end
        else if (cmd.emit_err)
        begin
            tile_x_reg <= '0;
            tile_y_reg <= '0;
            tile_w_reg <= '0;
            tile_h_reg <= '0;
            last_reg   <= 1'b1;
            err_reg    <= 1'b1;
        end
    end

    assign out_valid   = out_valid_reg;
    assign tile_x      = tile_x_reg;
    assign tile_y      = tile_y_reg;
    assign tile_width  = tile_w_reg;
    assign tile_height = tile_h_reg;
    assign last_tile   = last_reg;
    assign span_error  = err_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/rect_grid_tiler.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Splits one rectangle along a square grid of spacing 2^grid_size_log2 and
// sends one beat per grid cell touched, holding the rectangle clipped to that
// cell; cells go column by column with rows varying fastest, and the final
// beat of a rectangle has last_tile set. A rectangle spanning more than
// MAX_CELLS_PER_AXIS cells on either axis gives a single beat with span_error
// and last_tile set and all other fields zero; one covering no cell gives
// nothing. Each rectangle is accepted, planned and checked, then its tiles go
// out one per cycle from the cell walk counters while the tile side does not
// stall; an error rectangle gives its error beat after the check. A new
// rectangle is accepted only once the last one is through, while its last beat
// stays in the output register. grid_size_log2 is register 0 at byte address
// 0 and may only be written while the block is idle.
module rect_grid_tiler #(
    parameter int MAX_CELLS_PER_AXIS = 8,
    parameter int COORD_BITS         = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    rgt_rect_if.sink         rect,
    rgt_tile_if.source       tile
);
    import rgt_pkg::*;

    logic [LOG2_BITS-1:0] grid_log2;
    rgt_cmd_t             cmd;
    rgt_status_t          status;
    logic                 in_ready;

    rgt_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .grid_log2 (grid_log2)
    );

    rgt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (rect.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    assign rect.ready = in_ready;

    rgt_dp #(
        .MAX_CELLS_PER_AXIS (MAX_CELLS_PER_AXIS),
        .COORD_BITS         (COORD_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .grid_log2   (grid_log2),
        .cmd         (cmd),
        .status      (status),
        .rect_x      (rect.rect_x),
        .rect_y      (rect.rect_y),
        .rect_width  (rect.rect_width),
        .rect_height (rect.rect_height),
        .out_valid   (tile.valid),
        .out_ready   (tile.ready),
        .tile_x      (tile.tile_x),
        .tile_y      (tile.tile_y),
        .tile_width  (tile.tile_width),
        .tile_height (tile.tile_height),
        .last_tile   (tile.last_tile),
        .span_error  (tile.span_error)
    );

endmodule

`default_nettype wire

// ===== verif/rect_grid_tiler_test.sv =====
`timescale 1ns / 1ps

module rect_grid_tiler_test;
    import rgt_pkg::*;

    localparam int MAX_CELLS   = 8;
    localparam int COORD_W     = 16;
    localparam int STALL_LIMIT = 2000;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [EXTENT_BITS-1:0]    w;
        logic [EXTENT_BITS-1:0]    h;
        logic                      last;
        logic                      err;
    } tile_beat_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    rgt_rect_if #(.COORD_BITS(COORD_W)) rect_ch ();
    rgt_tile_if #(.COORD_BITS(COORD_W)) tile_ch ();

    rect_grid_tiler #(
        .MAX_CELLS_PER_AXIS(MAX_CELLS),
        .COORD_BITS(COORD_W)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .rect(rect_ch),
        .tile(tile_ch)
    );

    tile_beat_t           expected_tiles[$];
    logic [LOG2_BITS-1:0] grid_log2;
    int                   mismatches;
    int                   tile_stall;
    int                   quiet_cycles;
    bit                   steady;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    function automatic longint clamp_to(input longint v, input longint lo, input longint hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // walk the cells column by column, rows fastest, clipping the rect to each
    task automatic predict_tiles(input logic signed [COORD_W-1:0] x,
                                 input logic signed [COORD_W-1:0] y,
                                 input logic [EXTENT_BITS-1:0] w,
                                 input logic [EXTENT_BITS-1:0] h);
        longint     sx, sy, ex, ey, span;
        longint     col0, row0, col_end, row_end, col, row;
        longint     lo_x, lo_y, px, py, wx, wy;
        longint     total, n;
        tile_beat_t beat;
        sx = x;
        sy = y;
        ex = sx + longint'(w);
        ey = sy + longint'(h);
        span = longint'(1) << grid_log2;
        col0 = sx >>> grid_log2;
        row0 = sy >>> grid_log2;
        col_end = -((-ex) >>> grid_log2);
        row_end = -((-ey) >>> grid_log2);
        if (col_end - col0 > MAX_CELLS || row_end - row0 > MAX_CELLS)
        begin
            beat = '0;
            beat.last = 1'b1;
            beat.err = 1'b1;
            expected_tiles.push_back(beat);
        end
        else if (col_end - col0 > 0 && row_end - row0 > 0)
        begin
            total = (col_end - col0) * (row_end - row0);
            n = 0;
            for (col = col0; col < col_end; col++)
            begin
                for (row = row0; row < row_end; row++)
                begin
                    lo_x = col * span;
                    lo_y = row * span;
                    px = clamp_to(sx, lo_x, lo_x + span);
                    py = clamp_to(sy, lo_y, lo_y + span);
                    wx = clamp_to(ex, lo_x, lo_x + span) - px;
                    wy = clamp_to(ey, lo_y, lo_y + span) - py;
                    n++;
                    beat.x = px[COORD_W-1:0];
                    beat.y = py[COORD_W-1:0];
                    beat.w = wx[EXTENT_BITS-1:0];
                    beat.h = wy[EXTENT_BITS-1:0];
                    beat.last = (n == total);
                    beat.err = 1'b0;
                    expected_tiles.push_back(beat);
                end
            end
        end
    endtask

    task automatic send_rect(input logic signed [COORD_W-1:0] x,
                             input logic signed [COORD_W-1:0] y,
                             input logic [EXTENT_BITS-1:0] w,
                             input logic [EXTENT_BITS-1:0] h);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 3);
        repeat (gap)
        begin
            @(negedge clk);
            rect_ch.valid <= 1'b0;
        end
        @(negedge clk);
        rect_ch.valid <= 1'b1;
        rect_ch.rect_x <= x;
        rect_ch.rect_y <= y;
        rect_ch.rect_width <= w;
        rect_ch.rect_height <= h;
        do
            @(posedge clk);
        while (!rect_ch.ready);
        predict_tiles(x, y, w, h);
    endtask

    task automatic apb_access(input logic write, input logic [31:0] data,
                              output logic [31:0] rdata);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= write;
        paddr <= 3'(REG_GRID_SIZE_LOG2 * 4);
        pwdata <= data;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // let every outstanding tile drain, plus the plan/check cycles of an empty rect
    task automatic wait_idle();
        @(negedge clk);
        rect_ch.valid <= 1'b0;
        while (expected_tiles.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_spacing(input logic [LOG2_BITS-1:0] log2_val);
        logic [31:0] rd;
        wait_idle();
        apb_access(1'b1, 32'(log2_val), rd);
        grid_log2 = log2_val;
        apb_access(1'b0, 32'd0, rd);
        check_field("grid_size_log2", longint'(log2_val), longint'(rd[LOG2_BITS-1:0]));
    endtask

    function automatic logic [EXTENT_BITS-1:0] draw_extent();
        int     mode;
        longint reach;
        mode = $urandom_range(0, 9);
        reach = (longint'(1) << grid_log2) * MAX_CELLS;
        if (reach > 32767)
            reach = 32767;
        if (mode == 0)
            return '0;
        if (mode == 1)
            return EXTENT_BITS'($urandom_range(0, 32767));
        return EXTENT_BITS'($urandom_range(1, int'(reach)));
    endfunction

    function automatic logic signed [COORD_W-1:0] draw_coord();
        logic [COORD_W-1:0] v;
        v = COORD_W'($urandom);
        // snap to a grid line now and then so exact cell counts come up
        if ($urandom_range(0, 4) == 0)
            v = v & ~COORD_W'((longint'(1) << grid_log2) - 1);
        return v;
    endfunction

    task automatic send_random_rects(input int count);
        repeat (count)
            send_rect(draw_coord(), draw_coord(), draw_extent(), draw_extent());
    endtask

    task automatic test_reset_spacing_cases();
        logic [31:0] rd;
        apb_access(1'b0, 32'd0, rd);
        check_field("grid_size_log2", longint'(GRID_LOG2_RESET), longint'(rd[LOG2_BITS-1:0]));
        send_rect(16'sd0, 16'sd0, 15'd0, 15'd0);
        send_rect(16'sd0, 16'sd0, 15'd1024, 15'd1024);
        send_rect(-16'sd32768, -16'sd32768, 15'd0, 15'd0);
        send_rect(16'sd32767, 16'sd32767, 15'd32767, 15'd32767);
        send_rect(-16'sd32768, -16'sd32768, 15'd32767, 15'd32767);
        // zero extent away from a grid line still covers one cell
        send_rect(16'sd100, 16'sd200, 15'd0, 15'd50);
        send_rect(16'sd100, 16'sd200, 15'd50, 15'd0);
        send_rect(-16'sd5, -16'sd5, 15'd10, 15'd10);
        send_rect(16'sd0, 16'sd0, 15'd8192, 15'd8192);
        send_rect(16'sd0, 16'sd0, 15'd8193, 15'd100);
        send_rect(16'sd0, 16'sd0, 15'd100, 15'd8193);
        // too many columns wins over zero rows
        send_rect(16'sd0, 16'sd0, 15'd9216, 15'd0);
        // right cell edge past the signed range wraps
        send_rect(16'sd32767, -16'sd32768, 15'd5, 15'd5);
        send_rect(-16'sd1, -16'sd1, 15'd1, 15'd1);
        send_rect(-16'sd1024, 16'sd0, 15'd1025, 15'd1);
        send_rect(-16'sd32768, 16'sd32767, 15'd32767, 15'd0);
    endtask

    task automatic test_unit_spacing();
        set_spacing(4'd0);
        send_rect(16'sd3, -16'sd3, 15'd8, 15'd8);
        send_rect(16'sd0, 16'sd0, 15'd9, 15'd1);
        send_rect(16'sd0, 16'sd0, 15'd0, 15'd5);
        send_random_rects(40);
    endtask

    task automatic test_min_spacing();
        set_spacing(4'd1);
        send_rect(16'sd1, 16'sd1, 15'd0, 15'd0);
        send_random_rects(70);
    endtask

    task automatic test_max_spacing();
        set_spacing(4'd15);
        send_rect(16'sd32767, 16'sd32767, 15'd1, 15'd1);
        send_rect(-16'sd32768, -16'sd32768, 15'd32767, 15'd32767);
        send_rect(16'sd32000, 16'sd0, 15'd32767, 15'd1);
        send_random_rects(70);
    endtask

    task automatic test_back_to_back();
        set_spacing(4'd4);
        steady = 1'b1;
        send_random_rects(70);
        steady = 1'b0;
        send_random_rects(30);
    endtask

    task automatic test_random_spacing();
        repeat (5)
        begin
            set_spacing(LOG2_BITS'($urandom_range(1, 15)));
            send_random_rects(20);
        end
        set_spacing(GRID_LOG2_RESET);
        send_random_rects(20);
    endtask

    // result side back-pressure
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (tile_stall > 0)
            begin
                tile_ch.ready <= 1'b0;
                tile_stall--;
            end
            else
                tile_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        tile_beat_t want;
        if (rst_n && tile_ch.valid && tile_ch.ready)
        begin
            tile_stall = steady ? 0 : $urandom_range(0, 3);
            if (expected_tiles.size() == 0)
            begin
                $error("tile beat with nothing expected: x %0d y %0d",
                       tile_ch.tile_x, tile_ch.tile_y);
                mismatches++;
            end
            else
            begin
                want = expected_tiles.pop_front();
                check_field("tile_x", longint'(want.x), longint'(tile_ch.tile_x));
                check_field("tile_y", longint'(want.y), longint'(tile_ch.tile_y));
                check_field("tile_width", longint'(want.w), longint'(tile_ch.tile_width));
                check_field("tile_height", longint'(want.h), longint'(tile_ch.tile_height));
                check_field("last_tile", longint'(want.last), longint'(tile_ch.last_tile));
                check_field("span_error", longint'(want.err), longint'(tile_ch.span_error));
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((rect_ch.valid && rect_ch.ready) || (tile_ch.valid && tile_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("timeout: %0d tiles still expected", expected_tiles.size());
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        rect_ch.valid = 1'b0;
        rect_ch.rect_x = '0;
        rect_ch.rect_y = '0;
        rect_ch.rect_width = '0;
        rect_ch.rect_height = '0;
        tile_ch.ready = 1'b0;
        grid_log2 = GRID_LOG2_RESET;
        mismatches = 0;
        tile_stall = 0;
        quiet_cycles = 0;
        steady = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_spacing_cases();
        test_unit_spacing();
        test_min_spacing();
        test_max_spacing();
        test_back_to_back();
        test_random_spacing();
        wait_idle();

        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
